// ===== src/msde_pkg.sv =====
// Package: opcodes, funct codes, state enum and shared structs for the decode/execute unit
`default_nettype none
package msde_pkg;
  localparam int unsigned XLEN = 32;
  localparam int unsigned RIDX = 5;

  localparam logic [5:0] OP_SPECIAL = 6'b000000;
  localparam logic [5:0] OP_J       = 6'b000010;
  localparam logic [5:0] OP_BEQ     = 6'b000100;
  localparam logic [5:0] OP_BNE     = 6'b000101;
  localparam logic [5:0] OP_BLEZ    = 6'b000110;
  localparam logic [5:0] OP_BGTZ    = 6'b000111;
  localparam logic [5:0] OP_ADDI    = 6'b001000;
  localparam logic [5:0] OP_LUI     = 6'b001111;

  localparam logic [5:0] FN_SLL  = 6'b000000;
  localparam logic [5:0] FN_SRL  = 6'b000010;
  localparam logic [5:0] FN_JR   = 6'b001000;
  localparam logic [5:0] FN_MFHI = 6'b010000;
  localparam logic [5:0] FN_MFLO = 6'b010010;
  localparam logic [5:0] FN_MULT = 6'b011000;
  localparam logic [5:0] FN_DIV  = 6'b011010;
  localparam logic [5:0] FN_ADD  = 6'b100000;
  localparam logic [5:0] FN_SUB  = 6'b100010;
  localparam logic [5:0] FN_AND  = 6'b100100;
  localparam logic [5:0] FN_OR   = 6'b100101;
  localparam logic [5:0] FN_XOR  = 6'b100110;
  localparam logic [5:0] FN_SLT  = 6'b101010;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_MUL, ST_DIV, ST_DFIX, ST_OUT
  } state_t;

  // divider control/status
  typedef struct packed {
    logic            start;
    logic [XLEN-1:0] dividend;
    logic [XLEN-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [XLEN-1:0] quot;
    logic [XLEN-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic [XLEN-1:0] pc_after;
    logic            write_valid;
    logic [RIDX-1:0] write_index;
    logic [XLEN-1:0] write_value;
    logic [XLEN-1:0] hi_value;
    logic [XLEN-1:0] lo_value;
    logic            unsupported;
    logic            divide_by_zero;
  } result_t;
endpackage
`default_nettype wire

// ===== src/msde_if.sv =====
// Interfaces: valid/ready channels for instruction beats and result beats
`default_nettype none
interface msde_in_if import msde_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;
  modport source (output valid, output instruction_word, input ready);
  modport sink (input valid, input instruction_word, output ready);
endinterface

interface msde_out_if import msde_pkg::*; ();
  logic        valid;
  logic        ready;
  result_t     res;
  modport source (output valid, output res, input ready);
  modport sink (input valid, input res, output ready);
endinterface
`default_nettype wire

// ===== src/mips_subset_decode_execute_unit.sv =====
// Top level: sequencer, execute logic, HI/LO/PC and result register
//
//  channel | dir | signals
//  in_     | in  | valid, ready, instruction_word[31:0]
//  out_    | out | valid, ready, result_t fields
//
// Steps per instruction: accept, register read, execute, result (IDLE, READ, EXEC, OUT).
// MULT adds the MUL state for the registered product. DIV with a nonzero divisor
// waits in the one-bit-per-cycle divider, then adds the DFIX state for sign fixup.
// Reset clears HI, LO, PC and the register-file valid bits; the sequencer
// holds in the result state while out_ready is low.
`default_nettype none
module mips_subset_decode_execute_unit import msde_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  msde_in_if.sink    in_ch,
  msde_out_if.source out_ch
);
  state_t state_r, state_nxt;
  logic [31:0] iw_r;
  logic [XLEN-1:0] hi_r, lo_r, pc_r, hi_nxt, lo_nxt, pc_nxt;
  logic [31:0] vld_r;  // register written since reset
  result_t res_r, res_nxt;
  logic [XLEN-1:0] ra_q, rb_q, a, b, prod_r;
  logic [RIDX-1:0] ra_r, rb_r;
  logic we;
  logic [RIDX-1:0] wa;
  logic [XLEN-1:0] wd;
  div_req_t dreq;
  div_rsp_t drsp;

  wire [5:0] op = iw_r[31:26];
  wire [4:0] rs = iw_r[25:21];
  wire [4:0] rt = iw_r[20:16];
  wire [4:0] rd = iw_r[15:11];
  wire [4:0] sa = iw_r[10:6];
  wire [5:0] fn = iw_r[5:0];
  wire [XLEN-1:0] imm = {{16{iw_r[15]}}, iw_r[15:0]};

  msde_regfile u_rf (.clk, .ra_addr(rs), .rb_addr(rt), .ra_data(ra_q), .rb_data(rb_q),
    .we, .wa, .wd);
  msde_divider u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

  // read addresses come from the held instruction; data lands in EXEC
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid) begin
      ra_r <= in_ch.instruction_word[25:21];
      rb_r <= in_ch.instruction_word[20:16];
    end
  end
  assign a = (ra_r == '0 || !vld_r[ra_r]) ? '0 : ra_q;
  assign b = (rb_r == '0 || !vld_r[rb_r]) ? '0 : rb_q;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (op == OP_SPECIAL && fn == FN_MULT) state_nxt = ST_MUL;
        else if (op == OP_SPECIAL && fn == FN_DIV && b != '0) state_nxt = ST_DIV;
        else state_nxt = ST_OUT;
      end
      ST_MUL: state_nxt = ST_OUT;
      ST_DIV: if (drsp.done) state_nxt = ST_DFIX;
      ST_DFIX: state_nxt = ST_OUT;
      ST_OUT: if (out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // execute and outputs
  always_comb begin
    logic [XLEN-1:0] wv, rot, ua, ub, q, r;
    logic wr, uns, dz;
    wv = '0; wr = 1'b0; uns = 1'b0; dz = 1'b0;
    hi_nxt = hi_r; lo_nxt = lo_r; pc_nxt = pc_r;
    res_nxt = res_r;
    dreq = '0;
    ua = a[XLEN-1] ? -a : a;
    ub = b[XLEN-1] ? -b : b;
    rot = (b >> sa) | (b << (6'd32 - {1'b0, sa}));
    q = (a[XLEN-1] ^ b[XLEN-1]) ? -drsp.quot : drsp.quot;
    r = a[XLEN-1] ? -drsp.rem : drsp.rem;
    we = 1'b0; wa = '0; wd = '0;
    case (state_r)
      ST_EXEC: begin
        if (op == OP_SPECIAL) begin
          wr = 1'b1;
          case (fn)
            FN_SLL:  wv = b << sa;
            FN_SRL:  wv = iw_r[21] ? ((sa == '0) ? b : rot) : (b >> sa);
            FN_ADD:  wv = a + b;
            FN_SUB:  wv = a - b;
            FN_AND:  wv = a & b;
            FN_OR:   wv = a | b;
            FN_XOR:  wv = a ^ b;
            FN_SLT:  wv = {31'd0, $signed(a) < $signed(b)};
            FN_MFHI: wv = hi_r;
            FN_MFLO: wv = lo_r;
            FN_MULT: wr = 1'b0;
            FN_DIV: begin
              wr = 1'b0; dz = (b == '0);
              dreq.start = !dz; dreq.dividend = ua; dreq.divisor = ub;
            end
            FN_JR: begin wr = 1'b0; pc_nxt = a; end
            default: begin wr = 1'b0; uns = 1'b1; end
          endcase
          wa = rd;
        end else begin
          wa = rt;
          case (op)
            OP_ADDI: begin wr = 1'b1; wv = a + imm; end
            OP_LUI:  begin wr = 1'b1; wv = {iw_r[15:0], 16'd0}; end
            OP_BEQ:  if (a == b) pc_nxt = pc_r + imm;
            OP_BNE:  if (a != b) pc_nxt = pc_r + imm;
            OP_BLEZ: if (a[XLEN-1] || a == '0) pc_nxt = pc_r + imm;
            OP_BGTZ: if (!a[XLEN-1] && a != '0) pc_nxt = pc_r + imm;
            OP_J:    pc_nxt = pc_r + {{6{iw_r[25]}}, iw_r[25:0]};
            default: uns = 1'b1;
          endcase
        end
        if (wa == '0) wr = 1'b0;
        we = wr; wd = wv;
        res_nxt.write_valid    = wr;
        res_nxt.write_index    = wr ? wa : '0;
        res_nxt.write_value    = wr ? wv : '0;
        res_nxt.unsupported    = uns;
        res_nxt.divide_by_zero = dz;
        res_nxt.pc_after       = pc_nxt;
        res_nxt.hi_value       = hi_r;
        res_nxt.lo_value       = lo_r;
      end
      ST_MUL: begin
        lo_nxt = prod_r; res_nxt.lo_value = prod_r;
      end
      ST_DFIX: begin
        lo_nxt = q; hi_nxt = r;
        res_nxt.lo_value = q; res_nxt.hi_value = r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      hi_r <= '0; lo_r <= '0; pc_r <= '0; vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      hi_r <= hi_nxt; lo_r <= lo_nxt; pc_r <= pc_nxt;
      if (we) vld_r[wa] <= 1'b1;
    end
    if (state_r == ST_IDLE && in_ch.valid) iw_r <= in_ch.instruction_word;
    if (state_r == ST_EXEC) prod_r <= a * b;
    res_r <= res_nxt;
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.res   = res_r;

  // divider done only while the sequencer waits in DIV
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> state_r == ST_DIV) else $error("divider done outside DIV");
  a_no_write_r0: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> wa != '0) else $error("write to register zero");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.res))
    else $error("result changed while stalled");
endmodule
`default_nettype wire

// ===== src/msde_regfile.sv =====
// Register file: 32x32 synchronous memory, two registered read ports, one write port
`default_nettype none
module msde_regfile import msde_pkg::*; (
  input  wire logic            clk,
  input  wire logic [RIDX-1:0] ra_addr,
  input  wire logic [RIDX-1:0] rb_addr,
  output logic      [XLEN-1:0] ra_data,
  output logic      [XLEN-1:0] rb_data,
  input  wire logic            we,
  input  wire logic [RIDX-1:0] wa,
  input  wire logic [XLEN-1:0] wd
);
  logic [XLEN-1:0] mem [32];

  // reads and write never overlap in the sequencer, so no bypass
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end
endmodule
`default_nettype wire

// ===== src/msde_divider.sv =====
// Divider: unsigned restoring divider, one quotient bit per cycle
`default_nettype none
module msde_divider import msde_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic [XLEN-1:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [5:0]      cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt, done_r, done_nxt;
  logic [XLEN:0]   trial;

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {r_r, q_r[XLEN-1]} - {1'b0, d_r};
    if (req.start) begin
      q_nxt = req.dividend; r_nxt = '0; d_nxt = req.divisor;
      cnt_nxt = 6'(XLEN); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[XLEN]) begin
        r_nxt = {r_r[XLEN-2:0], q_r[XLEN-1]};
        q_nxt = {q_r[XLEN-2:0], 1'b0};
      end else begin
        r_nxt = trial[XLEN-1:0];
        q_nxt = {q_r[XLEN-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; r_r <= r_nxt; d_r <= d_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = r_r;
endmodule
`default_nettype wire
